### design/gbs_pkg.sv
package gbs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int KEPT_AW    = $clog2(MAX_KEPT);
    localparam int KEPT_CW    = $clog2(MAX_KEPT + 1);
    localparam int MAX_BOXES  = 4096;
    localparam int INDEX_W    = 12;
    localparam int AREA_W     = 30;
    localparam int UNION_W    = AREA_W + 1;
    localparam int THR_W      = 16;
    localparam int PROD_W     = UNION_W + THR_W;

    localparam logic [INDEX_W-1:0] INDEX_LIMIT =
        INDEX_W'(((MAX_BOXES - 1) < 4095) ? (MAX_BOXES - 1) : 4095);
    localparam logic [KEPT_CW-1:0] KEPT_FULL = KEPT_CW'(MAX_KEPT);
    localparam logic [THR_W-1:0]   THR_RESET = 16'd9830;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
    } box_t;

    typedef struct packed {
        box_t              box;
        logic [AREA_W-1:0] area;
    } kept_t;

    // status back from the compare pipeline
    typedef struct packed {
        logic busy;
        logic hit;
    } iou_stat_t;

endpackage

### design/gbs_box_if.sv
interface gbs_box_if;
    logic               valid;
    logic               ready;
    logic               first_of_frame;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_w;
    logic        [14:0] box_h;

    modport source (
        output valid, first_of_frame, box_x, box_y, box_w, box_h,
        input  ready
    );
    modport sink (
        input  valid, first_of_frame, box_x, box_y, box_w, box_h,
        output ready
    );
endinterface

### design/gbs_res_if.sv
interface gbs_res_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [11:0] box_index;
    logic        store_full;

    modport source (
        output valid, keep, box_index, store_full,
        input  ready
    );
    modport sink (
        input  valid, keep, box_index, store_full,
        output ready
    );
endinterface

### design/gbs_kept_mem.sv
module gbs_kept_mem
    import gbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [KEPT_AW-1:0] wr_addr,
    input  kept_t              wr_data,
    input  logic               rd_en,
    input  logic [KEPT_AW-1:0] rd_addr,
    output kept_t              rd_data,
    output logic               rd_valid
);

    kept_t mem [MAX_KEPT];
    kept_t rd_data_reg;
    logic  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### design/gbs_iou_unit.sv
module gbs_iou_unit
    import gbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  box_t              box_a,
    input  logic [AREA_W-1:0] area_a,
    input  logic [THR_W-1:0]  thr,
    input  logic              in_valid,
    input  kept_t             entry,
    output iou_stat_t         stat
);

    // stage 1: overlap extents
    logic signed [17:0] a_x0, a_x1, a_y0, a_y1, b_x0, b_x1, b_y0, b_y1;
    logic signed [17:0] lo_x, hi_x, lo_y, hi_y, dx, dy;
    logic [14:0]        iw_next, ih_next;
    logic [14:0]        iw_reg, ih_reg;
    logic [AREA_W-1:0]  area_b1_reg;
    logic               v1_reg;

    // stage 2: intersection and area sum
    logic [AREA_W-1:0]  inter2_reg;
    logic [UNION_W-1:0] sum2_reg;
    logic               v2_reg;

    // stage 3: union
    logic [AREA_W-1:0]  inter3_reg;
    logic [UNION_W-1:0] union3_reg;
    logic               v3_reg;

    // stage 4: threshold times union
    logic [AREA_W-1:0]  inter4_reg;
    logic [PROD_W-1:0]  prod4_reg;
    logic               v4_reg;

    // stage 5: compare
    logic               hit5_reg;
    logic               v5_reg;

    always_comb
    begin
        a_x0 = 18'(box_a.x);
        a_y0 = 18'(box_a.y);
        a_x1 = a_x0 + $signed({3'b000, box_a.w});
        a_y1 = a_y0 + $signed({3'b000, box_a.h});
        b_x0 = 18'(entry.box.x);
        b_y0 = 18'(entry.box.y);
        b_x1 = b_x0 + $signed({3'b000, entry.box.w});
        b_y1 = b_y0 + $signed({3'b000, entry.box.h});
        lo_x = (a_x0 > b_x0) ? a_x0 : b_x0;
        hi_x = (a_x1 < b_x1) ? a_x1 : b_x1;
        lo_y = (a_y0 > b_y0) ? a_y0 : b_y0;
        hi_y = (a_y1 < b_y1) ? a_y1 : b_y1;
        dx   = hi_x - lo_x;
        dy   = hi_y - lo_y;
        // a positive extent never exceeds the narrower box, so 15 bits hold it
        iw_next = (dx > 18'sd0) ? dx[14:0] : 15'd0;
        ih_next = (dy > 18'sd0) ? dy[14:0] : 15'd0;
    end

    always_ff @(posedge clk)
    begin
        iw_reg      <= iw_next;
        ih_reg      <= ih_next;
        area_b1_reg <= entry.area;
        inter2_reg  <= iw_reg * ih_reg;
        sum2_reg    <= UNION_W'(area_a) + UNION_W'(area_b1_reg);
        inter3_reg  <= inter2_reg;
        union3_reg  <= sum2_reg - UNION_W'(inter2_reg);
        inter4_reg  <= inter3_reg;
        prod4_reg   <= PROD_W'(thr) * PROD_W'(union3_reg);
        hit5_reg    <= {1'b0, inter4_reg, 16'h0000} > prod4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign stat.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign stat.hit  = v5_reg & hit5_reg;

endmodule

### design/greedy_box_suppression_top.sv
// Scan: each box is compared with the boxes kept so far in the frame (0 to 64),
//   one kept entry per cycle feeding a single five-stage IoU compare pipeline.
// Flow: one box at a time; the input opens only in the idle state, once the
//   result of the last box is registered. A result not yet taken holds the
//   next box in its done state, and the input stays closed.
// Reset: async active low; count, index, handshakes clear, threshold to 9830.
module greedy_box_suppression_top
    import gbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data,
    gbs_box_if.sink          boxes,
    gbs_res_if.source        results
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    box_t                box_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [KEPT_CW-1:0]  count_reg, count_next;
    logic [KEPT_CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [INDEX_W-1:0]  frame_reg, frame_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [INDEX_W-1:0]  frame_base;
    logic                sup_reg, sup_next;
    logic [THR_W-1:0]    thr_reg;

    logic                out_valid_reg, out_valid_next;
    logic                out_keep_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_full_reg;

    logic                in_xfer;
    logic                out_free;
    logic                finish;
    logic                rd_en;
    logic                wr_en;
    logic                store_room;
    kept_t               wr_data;
    kept_t               rd_data;
    logic                rd_valid;
    iou_stat_t           iou_stat;

    // Input is taken only between boxes; a finished result may still sit in
    // the output register while the next box scans.
    assign boxes.ready = (state_reg == ST_IDLE);
    assign in_xfer     = boxes.valid & boxes.ready;
    assign out_free    = ~out_valid_reg | results.ready;
    assign finish      = (state_reg == ST_DONE) & out_free;
    assign store_room  = (count_reg < KEPT_FULL);

    // One read per cycle over the kept entries of this frame.
    assign rd_en = (state_reg == ST_SCAN) & (rd_ptr_reg < count_reg);

    // Survivor goes to the next free slot; reads of that slot only start with
    // a later box, so no forwarding is needed.
    assign wr_en   = finish & ~sup_reg & store_room;
    assign wr_data = '{box: box_reg, area: area_reg};

    assign frame_base = boxes.first_of_frame ? '0 : frame_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        frame_next     = frame_reg;
        idx_next       = idx_reg;
        sup_next       = sup_reg | iou_stat.hit;
        out_valid_next = out_valid_reg & ~results.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // first-of-frame empties the store before the scan
                    count_next  = boxes.first_of_frame ? '0 : count_reg;
                    idx_next    = frame_base;
                    frame_next  = (frame_base < INDEX_LIMIT) ? frame_base + 1'b1
                                                             : frame_base;
                    rd_ptr_next = '0;
                    sup_next    = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // all hits are folded in once the pipe is empty
                if (!rd_valid && !iou_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (wr_en)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            frame_reg     <= '0;
            idx_reg       <= '0;
            sup_reg       <= 1'b0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            frame_reg     <= frame_next;
            idx_reg       <= idx_next;
            sup_reg       <= sup_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // Box payload and its area, captured at the input transfer; result fields at finish.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            box_reg.x <= boxes.box_x;
            box_reg.y <= boxes.box_y;
            box_reg.w <= boxes.box_w;
            box_reg.h <= boxes.box_h;
            area_reg  <= boxes.box_w * boxes.box_h;
        end
        if (finish)
        begin
            out_keep_reg  <= ~sup_reg;
            out_index_reg <= idx_reg;
            out_full_reg  <= ~sup_reg & ~store_room;
        end
    end

    gbs_kept_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[KEPT_AW-1:0]),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_ptr_reg[KEPT_AW-1:0]),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    gbs_iou_unit u_iou (
        .clk      (clk),
        .rst_n    (rst_n),
        .box_a    (box_reg),
        .area_a   (area_reg),
        .thr      (thr_reg),
        .in_valid (rd_valid),
        .entry    (rd_data),
        .stat     (iou_stat)
    );

    assign results.valid      = out_valid_reg;
    assign results.keep       = out_keep_reg;
    assign results.box_index  = out_index_reg;
    assign results.store_full = out_full_reg;

endmodule
